>>> sv/blr_pkg.sv
// blr_pkg: shared types and constants for the boundary length and regularity block
// no dependencies; imported by every module of the block
`default_nettype none

package blr_pkg;

	// fixed field widths of the point and result transfers
	localparam int COORD_FIELD_W = 16;
	localparam int LEN_SUM_W     = 27;
	localparam int SQ_SUM_W      = 44;
	localparam int REG_W         = 17;
	localparam int SEEN_W        = 11;

	// shared multiplier: operands wide enough for the length sum
	localparam int MUL_W      = LEN_SUM_W;
	localparam int PROD_W     = 2 * MUL_W;
	localparam int SQ_HALF_W  = SQ_SUM_W / 2;

	// fewest points that form one segment
	localparam int MIN_POINTS = 2;

	// saturation limits
	localparam logic [LEN_SUM_W-1:0] LEN_SUM_MAX = '1;
	localparam logic [SQ_SUM_W-1:0]  SQ_SUM_MAX  = '1;
	localparam logic [REG_W-1:0]     REG_MAX     = '1;

	// one input point
	typedef struct packed {
		logic signed [COORD_FIELD_W-1:0] x_mm;
		logic signed [COORD_FIELD_W-1:0] y_mm;
		logic                            last_point;
	} blr_in_t;

	// one segment result
	typedef struct packed {
		logic [LEN_SUM_W-1:0] total_length;
		logic [REG_W-1:0]     regularity;
		logic [SEEN_W-1:0]    points_seen;
		logic                 too_few;
		logic                 overflowed;
	} blr_out_t;

	// operations of the shared root / divide unit
	typedef enum logic [1:0] {
		OP_ROOT = 2'b01,
		OP_DIV  = 2'b10
	} blr_op_t;

	// command from the sequencer to the shared unit
	typedef struct packed {
		logic    start;
		blr_op_t op;
	} blr_cmd_t;

endpackage

`default_nettype wire

>>> sv/blr_iter.sv
// blr_iter: shared iterative unit, restoring integer square root and restoring division
// depends on blr_pkg (blr_cmd_t, blr_op_t)
`default_nettype none

module blr_iter import blr_pkg::*; #(
	parameter int W = 56,
	localparam int SW = $clog2(W + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  blr_cmd_t      cmd,
	input  logic [W-1:0]  operand,
	input  logic [W-1:0]  divisor,
	input  logic [SW-1:0] steps,
	output logic          done,
	output logic [W-1:0]  result
);

	logic          busy_q;
	logic          done_q;
	logic [SW-1:0] cnt_q;
	blr_op_t       op_q;
	logic [W-1:0]  opnd_q;
	logic [W-1:0]  div_q;
	logic [W:0]    rem_q;
	logic [W-1:0]  res_q;

	logic [W:0]    cand;
	logic [W:0]    trial;
	logic [W-1:0]  opnd_nxt;
	logic          ge;

	// one step: bring in the next one or two operand bits, trial subtract
	always_comb begin
		if (op_q == OP_DIV) begin
			cand     = {rem_q[W-1:0], opnd_q[W-1]};
			trial    = {1'b0, div_q};
			opnd_nxt = {opnd_q[W-2:0], 1'b0};
		end else begin
			cand     = {rem_q[W-2:0], opnd_q[W-1:W-2]};
			trial    = {res_q[W-2:0], 2'b01};
			opnd_nxt = {opnd_q[W-3:0], 2'b00};
		end
		ge = (cand >= trial);
	end

	// step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= OP_ROOT;
		end else begin
			done_q <= 1'b0;
			if (cmd.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
				op_q   <= cmd.op;
			end else if (busy_q) begin
				cnt_q <= cnt_q - SW'(1);
				if (cnt_q == SW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// operand, remainder and result datapath
	always_ff @(posedge clk) begin
		if (cmd.start && !busy_q) begin
			opnd_q <= operand;
			div_q  <= divisor;
			rem_q  <= '0;
			res_q  <= '0;
		end else if (busy_q) begin
			opnd_q <= opnd_nxt;
			rem_q  <= ge ? (cand - trial) : cand;
			res_q  <= {res_q[W-2:0], ge};
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

`default_nettype wire

>>> sv/boundary_length_and_regularity_top.sv
// Boundary length and regularity of one laser scan segment. Points arrive one per transfer
// (start high while busy is low); the point flagged last closes the segment and,
// then, one result is shown for exactly one cycle with done high. The receiver cannot stall,
// so the result must be taken in that cycle. A point that follows an earlier one runs the
// difference, square, root and accumulate states before the next transfer can be taken:
// the COORD_BITS + 1 steps of the shared square root unit and the multiply and accumulate
// steps around them. The first point of a segment and a point dropped for lack of room skip
// these states. Closing a segment of two or more points runs a bit-serial division over
// RAD_W steps (RAD_W is 56 at the defaults) and then a square root over RAD_W / 2 steps,
// both in the same unit. Sums and outputs saturate at their field widths.
// depends on blr_pkg and blr_iter
`default_nettype none

module boundary_length_and_regularity_top import blr_pkg::*; #(
	parameter int MAX_POINTS = 1024,
	parameter int COORD_BITS = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  blr_in_t  point,
	output logic     done,
	output blr_out_t result
);

	localparam int CW       = COORD_BITS;
	localparam int CNT_W    = $clog2(MAX_POINTS + 1);
	localparam int LEN_W    = CW + 1;
	localparam int A0       = CNT_W + SQ_SUM_W;
	localparam int A1       = (A0 > PROD_W) ? A0 : PROD_W;
	localparam int A2       = (A1 > 2 * CW + 1) ? A1 : 2 * CW + 1;
	localparam int RAD_W    = A2 + (A2 % 2);
	localparam int SW       = $clog2(RAD_W + 1);
	localparam int PT_SHIFT = RAD_W - 2 * LEN_W;

	typedef enum logic [14:0] {
		ST_IDLE  = 15'b000000000000001,
		ST_DIFF  = 15'b000000000000010,
		ST_SQX   = 15'b000000000000100,
		ST_SQY   = 15'b000000000001000,
		ST_RADD  = 15'b000000000010000,
		ST_ROOT  = 15'b000000000100000,
		ST_SACC  = 15'b000000001000000,
		ST_FIN   = 15'b000000010000000,
		ST_SS    = 15'b000000100000000,
		ST_NQL   = 15'b000001000000000,
		ST_NQH   = 15'b000010000000000,
		ST_AADD  = 15'b000100000000000,
		ST_CMP   = 15'b001000000000000,
		ST_DWAIT = 15'b010000000000000,
		ST_RWAIT = 15'b100000000000000
	} blr_state_t;

	blr_state_t             state_q;
	logic signed [CW-1:0]   prev_x_q;
	logic signed [CW-1:0]   prev_y_q;
	logic [CNT_W-1:0]       count_q;
	logic [LEN_SUM_W-1:0]   lsum_q;
	logic [SQ_SUM_W-1:0]    ssum_q;
	logic                   drop_q;
	logic                   done_q;

	logic signed [CW-1:0]   cur_x_q;
	logic signed [CW-1:0]   cur_y_q;
	logic [CW-1:0]          dx_q;
	logic [CW-1:0]          dy_q;
	logic                   last_q;
	logic [PROD_W-1:0]      prod_q;
	logic [RAD_W-1:0]       acc_q;
	logic [PROD_W-1:0]      b_q;
	blr_out_t               result_q;

	logic                   accept;
	logic [CW+COORD_FIELD_W-1:0] ext_x;
	logic [CW+COORD_FIELD_W-1:0] ext_y;
	logic signed [CW-1:0]   in_x;
	logic signed [CW-1:0]   in_y;
	logic signed [CW:0]     ddx;
	logic signed [CW:0]     ddy;
	logic signed [CW:0]     adx;
	logic signed [CW:0]     ady;

	logic                   mul_en;
	logic [MUL_W-1:0]       mul_a;
	logic [MUL_W-1:0]       mul_b;

	logic [LEN_W-1:0]       len;
	logic [LEN_SUM_W:0]     lsum_add;
	logic [PROD_W:0]        ssum_add;
	logic [REG_W-1:0]       reg_sat;

	blr_cmd_t               it_cmd;
	logic [RAD_W-1:0]       it_opnd;
	logic [RAD_W-1:0]       it_divisor;
	logic [SW-1:0]          it_steps;
	logic                   it_done;
	logic [RAD_W-1:0]       it_res;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// coordinates: low COORD_BITS of the field, sign taken from bit COORD_BITS-1
	assign ext_x = {{CW{1'b0}}, point.x_mm};
	assign ext_y = {{CW{1'b0}}, point.y_mm};
	assign in_x  = ext_x[CW-1:0];
	assign in_y  = ext_y[CW-1:0];

	// absolute coordinate differences to the previous point
	always_comb begin
		ddx = {cur_x_q[CW-1], cur_x_q} - {prev_x_q[CW-1], prev_x_q};
		ddy = {cur_y_q[CW-1], cur_y_q} - {prev_y_q[CW-1], prev_y_q};
		adx = ddx[CW] ? -ddx : ddx;
		ady = ddy[CW] ? -ddy : ddy;
	end

	// segment length from the shared unit and the saturating sums
	assign len      = it_res[LEN_W-1:0];
	assign lsum_add = (LEN_SUM_W + 1)'(lsum_q) + (LEN_SUM_W + 1)'(len);
	assign ssum_add = (PROD_W + 1)'(ssum_q) + (PROD_W + 1)'(prod_q);
	assign reg_sat  = (it_res > RAD_W'(REG_MAX)) ? REG_MAX : it_res[REG_W-1:0];

	// shared multiplier operand select
	always_comb begin
		mul_en = 1'b0;
		mul_a  = '0;
		mul_b  = '0;
		unique case (state_q)
			ST_SQX: begin
				mul_en = 1'b1;
				mul_a  = MUL_W'(dx_q);
				mul_b  = MUL_W'(dx_q);
			end
			ST_SQY: begin
				mul_en = 1'b1;
				mul_a  = MUL_W'(dy_q);
				mul_b  = MUL_W'(dy_q);
			end
			ST_ROOT: begin
				mul_en = it_done;
				mul_a  = MUL_W'(len);
				mul_b  = MUL_W'(len);
			end
			ST_SS: begin
				mul_en = 1'b1;
				mul_a  = MUL_W'(lsum_q);
				mul_b  = MUL_W'(lsum_q);
			end
			ST_NQL: begin
				mul_en = 1'b1;
				mul_a  = MUL_W'(count_q);
				mul_b  = MUL_W'(ssum_q[SQ_HALF_W-1:0]);
			end
			ST_NQH: begin
				mul_en = 1'b1;
				mul_a  = MUL_W'(count_q);
				mul_b  = MUL_W'(ssum_q[SQ_SUM_W-1:SQ_HALF_W]);
			end
			ST_AADD: begin
				mul_en = 1'b1;
				mul_a  = MUL_W'(count_q);
				mul_b  = MUL_W'(count_q - CNT_W'(1));
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	// commands to the shared root / divide unit
	always_comb begin
		it_cmd.start = 1'b0;
		it_cmd.op    = OP_ROOT;
		it_opnd      = '0;
		it_divisor   = '0;
		it_steps     = '0;
		unique case (state_q)
			ST_RADD: begin
				it_cmd.start = 1'b1;
				it_opnd      = (acc_q + RAD_W'(prod_q)) << PT_SHIFT;
				it_steps     = SW'(LEN_W);
			end
			ST_CMP: begin
				it_cmd.start = 1'b1;
				it_cmd.op    = OP_DIV;
				it_opnd      = (acc_q > RAD_W'(b_q)) ? (acc_q - RAD_W'(b_q)) : '0;
				it_divisor   = RAD_W'(prod_q);
				it_steps     = SW'(RAD_W);
			end
			ST_DWAIT: begin
				it_cmd.start = it_done;
				it_opnd      = it_res;
				it_steps     = SW'(RAD_W / 2);
			end
			default: begin
				it_cmd.start = 1'b0;
			end
		endcase
	end

	blr_iter #(
		.W(RAD_W)
	) u_iter (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (it_cmd),
		.operand (it_opnd),
		.divisor (it_divisor),
		.steps   (it_steps),
		.done    (it_done),
		.result  (it_res)
	);

	// sequencer and segment state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			prev_x_q <= '0;
			prev_y_q <= '0;
			count_q  <= '0;
			lsum_q   <= '0;
			ssum_q   <= '0;
			drop_q   <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (count_q >= CNT_W'(MAX_POINTS)) begin
							drop_q  <= 1'b1;
							state_q <= point.last_point ? ST_FIN : ST_IDLE;
						end else if (count_q == '0) begin
							prev_x_q <= in_x;
							prev_y_q <= in_y;
							count_q  <= count_q + CNT_W'(1);
							state_q  <= point.last_point ? ST_FIN : ST_IDLE;
						end else begin
							state_q <= ST_DIFF;
						end
					end
				end
				ST_DIFF: begin
					prev_x_q <= cur_x_q;
					prev_y_q <= cur_y_q;
					count_q  <= count_q + CNT_W'(1);
					state_q  <= ST_SQX;
				end
				ST_SQX:  state_q <= ST_SQY;
				ST_SQY:  state_q <= ST_RADD;
				ST_RADD: state_q <= ST_ROOT;
				ST_ROOT: begin
					if (it_done) begin
						lsum_q  <= lsum_add[LEN_SUM_W] ? LEN_SUM_MAX : lsum_add[LEN_SUM_W-1:0];
						state_q <= ST_SACC;
					end
				end
				ST_SACC: begin
					ssum_q  <= (ssum_add > (PROD_W + 1)'(SQ_SUM_MAX)) ? SQ_SUM_MAX
						: ssum_add[SQ_SUM_W-1:0];
					state_q <= last_q ? ST_FIN : ST_IDLE;
				end
				ST_FIN: begin
					if (count_q < CNT_W'(MIN_POINTS)) begin
						done_q   <= 1'b1;
						prev_x_q <= '0;
						prev_y_q <= '0;
						count_q  <= '0;
						lsum_q   <= '0;
						ssum_q   <= '0;
						drop_q   <= 1'b0;
						state_q  <= ST_IDLE;
					end else begin
						state_q <= ST_SS;
					end
				end
				ST_SS:   state_q <= ST_NQL;
				ST_NQL:  state_q <= ST_NQH;
				ST_NQH:  state_q <= ST_AADD;
				ST_AADD: state_q <= ST_CMP;
				ST_CMP:  state_q <= ST_DWAIT;
				ST_DWAIT: begin
					if (it_done) begin
						state_q <= ST_RWAIT;
					end
				end
				ST_RWAIT: begin
					if (it_done) begin
						done_q   <= 1'b1;
						prev_x_q <= '0;
						prev_y_q <= '0;
						count_q  <= '0;
						lsum_q   <= '0;
						ssum_q   <= '0;
						drop_q   <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_x_q <= in_x;
			cur_y_q <= in_y;
			last_q  <= point.last_point;
		end
		if (state_q == ST_DIFF) begin
			dx_q <= adx[CW-1:0];
			dy_q <= ady[CW-1:0];
		end
		if (mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		// partial sums: dx squared, then n times the square sum
		if (state_q == ST_SQY || state_q == ST_NQH) begin
			acc_q <= RAD_W'(prod_q);
		end
		if (state_q == ST_AADD) begin
			acc_q <= acc_q + (RAD_W'(prod_q) << SQ_HALF_W);
		end
		if (state_q == ST_NQL) begin
			b_q <= prod_q;
		end
		// result fields
		if (state_q == ST_FIN) begin
			result_q.total_length <= '0;
			result_q.regularity   <= '0;
			result_q.points_seen  <= SEEN_W'(count_q);
			result_q.too_few      <= 1'b1;
			result_q.overflowed   <= drop_q;
		end
		if (state_q == ST_RWAIT) begin
			result_q.total_length <= lsum_q;
			result_q.regularity   <= reg_sat;
			result_q.points_seen  <= SEEN_W'(count_q);
			result_q.too_few      <= 1'b0;
			result_q.overflowed   <= drop_q;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

>>> sv/blr_checker.sv
// blr_checker: port-level checks of the boundary length and regularity block, and its bind
// depends on blr_pkg and boundary_length_and_regularity_top
`default_nettype none

module blr_checker import blr_pkg::*; (
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     start,
	input wire logic     busy,
	input wire blr_in_t  point,
	input wire logic     done,
	input wire blr_out_t result
);

	// a point transfer never coincides with a result about to be shown
	a_no_result_after_point: assert property (
		@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !done
	) else $error("result shown right after a point transfer");

	// results are single-cycle strobes, never back to back
	a_single_strobe: assert property (
		@(posedge clk) disable iff (!arst_n)
		done |=> !done
	) else $error("result strobe held for two cycles");

	// a short segment reports zeros and a count below two
	a_too_few_zero: assert property (
		@(posedge clk) disable iff (!arst_n)
		(done && result.too_few) |->
			(result.total_length == '0 && result.regularity == '0 &&
			(result.points_seen == SEEN_W'(0) || result.points_seen == SEEN_W'(1)))
	) else $error("short segment with nonzero fields");

	// deviation of nonnegative lengths never exceeds their sum
	a_reg_bound: assert property (
		@(posedge clk) disable iff (!arst_n)
		(done && !result.too_few) |->
			(LEN_SUM_W'(result.regularity) <= result.total_length)
	) else $error("regularity above total length");

endmodule

bind boundary_length_and_regularity_top blr_checker u_blr_checker (.*);

`default_nettype wire

>>> tb/sv/tb_boundary_length_and_regularity_top.sv
// self-checking testbench for boundary_length_and_regularity_top: scan points in, segment results out
// depends on blr_pkg and the rtl of the block; predicts each segment result and compares on done
`default_nettype none

module tb_boundary_length_and_regularity_top;
	import blr_pkg::*;

	localparam int MAX_POINTS   = 1024;
	localparam int COORD_BITS   = 16;
	localparam int TARGET_ITEMS = 1350;
	localparam int DRAIN_CYCLES = 300;
	localparam int LIMIT_CYCLES = 500000;

	// one scan point waiting to be driven, with its sender idle rate
	typedef struct {
		blr_in_t     pt;
		int unsigned idle_pct;
	} scan_item_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	blr_in_t  point = '0;
	logic     busy;
	logic     done;
	blr_out_t result;

	scan_item_t  pending_points[$];
	blr_out_t    expected_results[$];
	bit          point_taken = 1'b0;
	int unsigned item_count = 0;
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;

	// running segment state of the predictor
	longint          seg_prev_x = 0;
	longint          seg_prev_y = 0;
	int unsigned     seg_count = 0;
	longint unsigned seg_len_sum = 0;
	longint unsigned seg_sq_sum = 0;
	bit              seg_dropped = 1'b0;

	boundary_length_and_regularity_top #(
		.MAX_POINTS(MAX_POINTS),
		.COORD_BITS(COORD_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.point(point),
		.done(done),
		.result(result)
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// floor square root, one result bit per step from the top
	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned root;
		longint unsigned trial;
		int              b;
		root = 0;
		for (b = 31; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= v) root = trial;
		end
		return root;
	endfunction

	// coordinate as a signed value of COORD_BITS bits
	function automatic longint sign_coord(input logic [COORD_FIELD_W-1:0] v);
		longint w;
		w = longint'(v);
		return (w <<< (64 - COORD_BITS)) >>> (64 - COORD_BITS);
	endfunction

	// advance the segment state by one accepted point; queue a result on the last one
	task automatic predict_segment(input blr_in_t pt);
		longint          sx;
		longint          sy;
		longint          dx;
		longint          dy;
		longint unsigned seg_len;
		longint unsigned n;
		longint unsigned lhs;
		longint unsigned rhs;
		longint unsigned dev;
		blr_out_t        res;
		sx = sign_coord(pt.x_mm);
		sy = sign_coord(pt.y_mm);
		if (seg_count >= MAX_POINTS) begin
			seg_dropped = 1'b1;
		end else begin
			if (seg_count > 0) begin
				dx = sx - seg_prev_x;
				dy = sy - seg_prev_y;
				seg_len = int_sqrt(unsigned'(dx * dx + dy * dy));
				seg_len_sum = seg_len_sum + seg_len;
				if (seg_len_sum > LEN_SUM_MAX) seg_len_sum = LEN_SUM_MAX;
				seg_sq_sum = seg_sq_sum + seg_len * seg_len;
				if (seg_sq_sum > SQ_SUM_MAX) seg_sq_sum = SQ_SUM_MAX;
			end
			seg_prev_x = sx;
			seg_prev_y = sy;
			seg_count++;
		end
		if (pt.last_point) begin
			res = '0;
			n = seg_count;
			res.points_seen = n[SEEN_W-1:0];
			res.too_few = (n < MIN_POINTS);
			res.overflowed = seg_dropped;
			if (n >= MIN_POINTS) begin
				// deviation over n points; zero spread gives no radicand
				lhs = n * seg_sq_sum;
				rhs = seg_len_sum * seg_len_sum;
				dev = 0;
				if (lhs > rhs) dev = int_sqrt((lhs - rhs) / (n * (n - 1)));
				if (dev > REG_MAX) dev = REG_MAX;
				res.regularity = dev[REG_W-1:0];
				res.total_length = seg_len_sum[LEN_SUM_W-1:0];
			end
			expected_results.insert(expected_results.size(), res);
			seg_prev_x = 0;
			seg_prev_y = 0;
			seg_count = 0;
			seg_len_sum = 0;
			seg_sq_sum = 0;
			seg_dropped = 1'b0;
		end
	endtask

	task automatic check_field(input string name, input longint unsigned exp_v,
			input longint unsigned act_v);
		if (exp_v != act_v) begin
			error_count++;
			$display("%0t: mismatch on %s: expected %0d, got %0d", $time, name, exp_v, act_v);
		end
	endtask

	// queue one point; the idle rate follows the item index through three phases
	task automatic add_point(input logic [15:0] x, input logic [15:0] y, input bit last);
		scan_item_t item;
		int unsigned phase_pct[3];
		phase_pct = '{0, 51, 8};
		item.pt.x_mm = x;
		item.pt.y_mm = y;
		item.pt.last_point = last;
		item.idle_pct = phase_pct[(item_count / 120) % 3];
		pending_points.insert(pending_points.size(), item);
		item_count++;
	endtask

	function automatic logic [15:0] corner_coord();
		logic [15:0] corners[5];
		corners = '{16'h8000, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF};
		return corners[$urandom_range(4)];
	endfunction

	// one whole segment: full-range, random walk, corner or mixed points
	task automatic add_segment(input int unsigned n_pts);
		int unsigned style;
		int unsigned i;
		logic [15:0] x;
		logic [15:0] y;
		style = $urandom_range(3);
		x = 16'($urandom);
		y = 16'($urandom);
		for (i = 0; i < n_pts; i++) begin
			case (style)
				0: begin
					x = 16'($urandom);
					y = 16'($urandom);
				end
				1: begin
					x = x + 16'($urandom_range(400)) - 16'd200;
					y = y + 16'($urandom_range(400)) - 16'd200;
				end
				2: begin
					x = corner_coord();
					y = corner_coord();
				end
				default: begin
					x = ($urandom_range(1)) ? corner_coord() : 16'($urandom);
					y = ($urandom_range(1)) ? 16'($urandom_range(50)) : 16'($urandom);
				end
			endcase
			add_point(x, y, i == n_pts - 1);
		end
	endtask

	// stimulus, reset and end of run
	initial begin
		int unsigned pick;
		bit          capacity_done;
		capacity_done = 1'b0;

		// single point: too few
		add_point(16'd0, 16'd0, 1'b1);
		// longest possible segment, corner to corner
		add_point(16'h8000, 16'h8000, 1'b0);
		add_point(16'h7FFF, 16'h7FFF, 1'b1);
		// zero-length segment
		add_point(16'd5, 16'd5, 1'b0);
		add_point(16'd5, 16'd5, 1'b1);
		// uneven lengths 5 and 0
		add_point(16'd0, 16'd0, 1'b0);
		add_point(16'd3, 16'd4, 1'b0);
		add_point(16'd3, 16'd4, 1'b1);
		// mixed-sign extremes
		add_point(16'h7FFF, 16'h8000, 1'b0);
		add_point(16'h8000, 16'h7FFF, 1'b0);
		add_point(16'd0, 16'd0, 1'b0);
		add_point(16'hFFFF, 16'hFFFF, 1'b1);
		// equal lengths along x
		add_point(16'd0, 16'd0, 1'b0);
		add_point(16'd10, 16'd0, 1'b0);
		add_point(16'd20, 16'd0, 1'b0);
		add_point(16'd30, 16'd0, 1'b1);
		// y axis only, full span
		add_point(16'd0, 16'h8000, 1'b0);
		add_point(16'd0, 16'h7FFF, 1'b1);
		// back to a single point after full segments
		add_point(16'hFFFF, 16'h0001, 1'b1);

		// random segments, one over capacity partway through
		while (item_count < TARGET_ITEMS) begin
			if (!capacity_done && item_count >= 170) begin
				add_segment(MAX_POINTS + $urandom_range(1, 4));
				capacity_done = 1'b1;
			end else begin
				pick = $urandom_range(99);
				if (pick < 10) add_segment(1);
				else if (pick < 80) add_segment($urandom_range(2, 8));
				else add_segment($urandom_range(9, 40));
			end
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_points.size() != 0 || expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && expected_results.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// driver: hold a point while the block is busy, otherwise idle or present the next
	always @(negedge clk) begin
		bit hold;
		if (arst_n) begin
			hold = start && busy && !point_taken;
			if (point_taken) begin
				void'(pending_points.pop_front());
				point_taken = 1'b0;
			end
			if (!hold) begin
				if (pending_points.size() > 0 &&
						$urandom_range(99) >= pending_points[0].idle_pct) begin
					point <= pending_points[0].pt;
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: check results on done, predict on each point transfer
	always @(posedge clk) begin
		blr_out_t exp_res;
		if (arst_n) begin
			if (done) begin
				if (expected_results.size() == 0) begin
					error_count++;
					$display("%0t: result with none expected: %p", $time, result);
				end else begin
					exp_res = expected_results.pop_front();
					check_field("total_length", exp_res.total_length, result.total_length);
					check_field("regularity", exp_res.regularity, result.regularity);
					check_field("points_seen", exp_res.points_seen, result.points_seen);
					check_field("too_few", exp_res.too_few, result.too_few);
					check_field("overflowed", exp_res.overflowed, result.overflowed);
				end
			end
			if (start && !busy) begin
				predict_segment(point);
				point_taken = 1'b1;
			end
		end
	end

	// timeout
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("FAIL");
			$finish;
		end
	end

endmodule

`default_nettype wire
